/* hw/rtl/scc_pkg.sv */
`default_nettype none

package scc_pkg;

	// Fixed field widths of the block's ports and internal registers.
	localparam int VTX_W   = 8;
	localparam int EDGE_W  = 2 * VTX_W;
	localparam int ID_W    = 6;
	localparam int NC_W    = 7;
	localparam int VISIT_W = 9;
	localparam int VCNT_W  = 9;
	localparam int REACH_W = 64;
	localparam int OP_W    = 3;

	// Default sizes of the stores.
	localparam int DEF_VERTICES             = 256;
	localparam int DEF_MAX_DIRECTED_EDGES   = 512;
	localparam int DEF_MAX_UNDIRECTED_EDGES = 256;
	localparam int DEF_COMPONENT_LIMIT      = 64;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR       = 3'd0,
		OP_NEW_GRAPH   = 3'd1,
		OP_MARK_ROOT   = 3'd2,
		OP_DIR_EDGE    = 3'd3,
		OP_UND_EDGE    = 3'd4,
		OP_COMPUTE     = 3'd5,
		OP_READ_VERTEX = 3'd6,
		OP_READ_COMP   = 3'd7
	} op_t;

	// Commands from the sequencer to the edge store.
	typedef struct packed {
		logic clr_dir;
		logic clr_und;
		logic wr_dir;
		logic wr_und;
	} edge_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/strong_component_closure.sv */
`default_nettype none

// Strong-component search with transitive closure of the condensation.
//
// Commands enter on start when busy is low, with the operation code and its
// vertex and component arguments. Every command gives exactly one result
// transaction: done is high for one cycle with component_id, reach_set,
// component_count and overflow. The receiver cannot stall, so a result is
// simply taken in the cycle done is high.
// Clear, new graph, mark root and edge loads answer in the cycle after they
// are accepted and busy never rises, so these commands may be issued back to
// back. A component read passes through the registered reach store read, a
// vertex read through the component map and then the reach store. A compute
// walks the graph with one sequencer: it scans the root slots, checks each
// edge (opening a child there, or on a visited vertex still on the stack
// updating the low link), pops closed components and restores parent frames.
// The closure then ORs, for each component and each directed edge starting in
// it, the reach mask of the target's component into that component's mask.
// The vertex_count register is written through cfg_valid/cfg_ready; the user
// must write it only while the block is idle, which the block itself never
// checks; cfg_ready is always high. Reset empties the graph, the results and
// the overflow flag and sets vertex_count to 256; valid bits make the cleared
// stores read as zero at once, so no clearing pass is needed.
module strong_component_closure #(
	parameter int VERTICES             = scc_pkg::DEF_VERTICES,
	parameter int MAX_DIRECTED_EDGES   = scc_pkg::DEF_MAX_DIRECTED_EDGES,
	parameter int MAX_UNDIRECTED_EDGES = scc_pkg::DEF_MAX_UNDIRECTED_EDGES,
	parameter int COMPONENT_LIMIT      = scc_pkg::DEF_COMPONENT_LIMIT
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [scc_pkg::OP_W-1:0]      operation,
	input  wire [scc_pkg::VTX_W-1:0]     first_vertex,
	input  wire [scc_pkg::VTX_W-1:0]     second_vertex,
	input  wire [scc_pkg::ID_W-1:0]      component_index,
	output logic                         done,
	output logic [scc_pkg::ID_W-1:0]     component_id,
	output logic [scc_pkg::REACH_W-1:0]  reach_set,
	output logic [scc_pkg::ID_W-1:0]     component_count,
	output logic                         overflow,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [scc_pkg::VCNT_W-1:0]    cfg_data
);
	import scc_pkg::*;

	// Vertex fields are eight bits wide, so no vertex beyond 255 can ever be
	// reached; the per-vertex stores only need the slots below that.
	localparam int VSLOTS = (VERTICES < 256) ? VERTICES : 256;
	localparam int VW     = $clog2(VSLOTS);
	localparam int VCW    = VW + 1;
	localparam int DAW    = (MAX_DIRECTED_EDGES > 1) ? $clog2(MAX_DIRECTED_EDGES) : 1;
	localparam int UAW    = (MAX_UNDIRECTED_EDGES > 1) ? $clog2(MAX_UNDIRECTED_EDGES) : 1;
	localparam int DTW    = $clog2(MAX_DIRECTED_EDGES + 1);
	localparam int UTW    = $clog2(MAX_UNDIRECTED_EDGES + 1);
	localparam int XW     = $clog2(MAX_DIRECTED_EDGES + 2 * MAX_UNDIRECTED_EDGES + 1);
	localparam int CIW    = $clog2(COMPONENT_LIMIT);
	localparam int FW     = VTX_W + XW + 2 * VISIT_W;

	typedef enum logic [16:0] {
		S_IDLE   = 17'b1 << 0,
		S_Q1     = 17'b1 << 1,
		S_Q2     = 17'b1 << 2,
		S_SCAN   = 17'b1 << 3,
		S_FETCH  = 17'b1 << 4,
		S_EDGE   = 17'b1 << 5,
		S_LOW    = 17'b1 << 6,
		S_FIN    = 17'b1 << 7,
		S_POPR   = 17'b1 << 8,
		S_POPW   = 17'b1 << 9,
		S_RET    = 17'b1 << 10,
		S_REST   = 17'b1 << 11,
		S_CFETCH = 17'b1 << 12,
		S_CCOMP  = 17'b1 << 13,
		S_CREACH = 17'b1 << 14,
		S_COR    = 17'b1 << 15,
		S_CWRITE = 17'b1 << 16
	} state_t;

	state_t              state_q;
	logic [VCNT_W-1:0]   vcount_q;
	logic [VSLOTS-1:0]   root_q;
	logic [VSLOTS-1:0]   vis_valid_q;
	logic [VSLOTS-1:0]   onstk_q;
	logic [COMPONENT_LIMIT-1:0] rvalid_q;
	logic [VISIT_W-1:0]  visit_ctr_q;
	logic [NC_W-1:0]     next_comp_q;
	logic                ovf_q;
	logic [VCW-1:0]      scan_q;
	logic [VCW-1:0]      depth_q;
	logic [VCW-1:0]      sp_q;

	// The frame on top of the search is held in registers; the frames of
	// its ancestors live in the frame memory.
	logic [VTX_W-1:0]    cur_v_q;
	logic [XW-1:0]       cur_cur_q;
	logic [VISIT_W-1:0]  cur_low_q;
	logic [VISIT_W-1:0]  cur_num_q;
	logic                fsel_q;
	logic                fpar_q;
	logic [ID_W-1:0]     comp_id_q;

	logic [NC_W-1:0]     cls_c_q;
	logic [DTW-1:0]      cls_e_q;
	logic [REACH_W-1:0]  cls_s_q;
	logic                cls_ok_q;
	logic                q_ok_q;
	logic                r_ok_q;

	logic                done_q;
	logic [ID_W-1:0]     out_id_q;
	logic [REACH_W-1:0]  out_reach_q;

	// Memories and their registered read data.
	logic [VISIT_W-1:0]  vis_mem   [VSLOTS];
	logic [VTX_W-1:0]    vstk_mem  [VSLOTS];
	logic [FW-1:0]       frm_mem   [VSLOTS];
	logic [ID_W-1:0]     comp_mem  [VSLOTS];
	logic [REACH_W-1:0]  reach_mem [COMPONENT_LIMIT];
	logic [VISIT_W-1:0]  vis_rd_q;
	logic [VTX_W-1:0]    vstk_rd_q;
	logic [FW-1:0]       frm_rd_q;
	logic [ID_W-1:0]     comp_rd_a_q;
	logic [ID_W-1:0]     comp_rd_b_q;
	logic                cv_a_q;
	logic                cv_b_q;
	logic [REACH_W-1:0]  reach_rd_q;
	logic                rv_q;

	// Edge store connections.
	edge_ctl_t           ectl;
	logic [DAW-1:0]      dir_raddr;
	logic [UAW-1:0]      und_raddr;
	logic [DTW-1:0]      dir_total;
	logic [UTW-1:0]      und_total;
	logic [EDGE_W-1:0]   dir_rdata;
	logic [EDGE_W-1:0]   und_rdata;

	// Combinational control.
	logic                accept;
	op_t                 op;
	logic [XW-1:0]       edge_span;
	logic [XW-1:0]       udiff;
	logic                fetch_end;
	logic                is_dir;
	logic [VTX_W-1:0]    ea;
	logic [VTX_W-1:0]    eb;
	logic                cand;
	logic [VTX_W-1:0]    cand_w;
	logic                scan_end;
	logic [VTX_W-1:0]    scan_v;
	logic                root_hit;
	logic                do_open;
	logic [VTX_W-1:0]    open_v;
	logic [VW-1:0]       vstk_raddr;
	logic [VW-1:0]       frm_raddr;
	logic [VW-1:0]       comp_raddr_a;
	logic [VW-1:0]       comp_raddr_b;
	logic [CIW-1:0]      reach_raddr;
	logic [ID_W-1:0]     qid;
	logic [ID_W-1:0]     ca;
	logic [ID_W-1:0]     cb;
	logic                dir_full;
	logic                und_full;

	function automatic logic in_rng(input logic [VTX_W-1:0] x);
		return ({1'b0, x} < vcount_q) && (int'(x) < VSLOTS);
	endfunction

	assign accept    = start && !busy;
	assign op        = op_t'(operation);
	assign dir_full  = (int'(dir_total) == MAX_DIRECTED_EDGES);
	assign und_full  = (int'(und_total) == MAX_UNDIRECTED_EDGES);

	// Child scan: the cursor runs over directed edges, then twice over each
	// undirected edge, once per direction.
	assign edge_span = XW'(dir_total) + (XW'(und_total) << 1);
	assign udiff     = cur_cur_q - XW'(dir_total);
	assign fetch_end = (cur_cur_q >= edge_span);
	assign is_dir    = (cur_cur_q < XW'(dir_total));

	always_comb begin
		ea     = fsel_q ? und_rdata[EDGE_W-1 -: VTX_W] : dir_rdata[EDGE_W-1 -: VTX_W];
		eb     = fsel_q ? und_rdata[VTX_W-1:0] : dir_rdata[VTX_W-1:0];
		cand   = 1'b0;
		cand_w = eb;
		if (in_rng(ea) && in_rng(eb)) begin
			if (!fsel_q || !fpar_q) begin
				cand   = (ea == cur_v_q);
				cand_w = eb;
			end else begin
				cand   = (eb == cur_v_q);
				cand_w = ea;
			end
		end
	end

	assign scan_end = (int'(scan_q) >= VSLOTS);
	assign scan_v   = VTX_W'(scan_q[VW-1:0]);
	assign root_hit = !scan_end && root_q[scan_q[VW-1:0]] && in_rng(scan_v)
		&& !vis_valid_q[scan_q[VW-1:0]];

	always_comb begin
		do_open = 1'b0;
		open_v  = scan_v;
		if (state_q == S_SCAN && root_hit) begin
			do_open = 1'b1;
		end else if (state_q == S_EDGE && cand && !vis_valid_q[cand_w[VW-1:0]]) begin
			do_open = 1'b1;
			open_v  = cand_w;
		end
	end

	assign vstk_raddr   = VW'(sp_q - VCW'(1));
	assign frm_raddr    = VW'(depth_q - VCW'(2));
	assign comp_raddr_a = (state_q == S_CCOMP) ? dir_rdata[VTX_W +: VW]
		: first_vertex[VW-1:0];
	assign comp_raddr_b = dir_rdata[VW-1:0];
	assign qid          = (q_ok_q && cv_a_q) ? comp_rd_a_q : '0;
	assign ca           = cv_a_q ? comp_rd_a_q : '0;
	assign cb           = cv_b_q ? comp_rd_b_q : '0;

	always_comb begin
		unique case (state_q)
			S_Q1:     reach_raddr = qid[CIW-1:0];
			S_CREACH: reach_raddr = cb[CIW-1:0];
			default:  reach_raddr = component_index[CIW-1:0];
		endcase
	end

	assign dir_raddr = (state_q == S_FETCH) ? cur_cur_q[DAW-1:0] : cls_e_q[DAW-1:0];
	assign und_raddr = udiff[UAW:1];

	always_comb begin
		ectl.clr_dir = accept && (op == OP_CLEAR);
		ectl.clr_und = accept && ((op == OP_CLEAR) || (op == OP_NEW_GRAPH));
		ectl.wr_dir  = accept && (op == OP_DIR_EDGE);
		ectl.wr_und  = accept && (op == OP_UND_EDGE);
	end

	scc_edge_store #(
		.MAX_DIRECTED_EDGES   (MAX_DIRECTED_EDGES),
		.MAX_UNDIRECTED_EDGES (MAX_UNDIRECTED_EDGES)
	) u_edges (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ectl),
		.wr_data   ({first_vertex, second_vertex}),
		.dir_raddr (dir_raddr),
		.und_raddr (und_raddr),
		.dir_total (dir_total),
		.und_total (und_total),
		.dir_rdata (dir_rdata),
		.und_rdata (und_rdata)
	);

	// Visit numbers: written when a vertex opens, read for the low-link update.
	always_ff @(posedge clk) begin
		if (do_open) begin
			vis_mem[open_v[VW-1:0]] <= visit_ctr_q;
		end
		vis_rd_q <= vis_mem[cand_w[VW-1:0]];
	end

	// Vertex stack.
	always_ff @(posedge clk) begin
		if (do_open) begin
			vstk_mem[sp_q[VW-1:0]] <= open_v;
		end
		vstk_rd_q <= vstk_mem[vstk_raddr];
	end

	// Saved frames of the ancestors of the current vertex.
	always_ff @(posedge clk) begin
		if (do_open && depth_q != '0) begin
			frm_mem[VW'(depth_q - VCW'(1))] <= {cur_v_q, cur_cur_q, cur_low_q, cur_num_q};
		end
		frm_rd_q <= frm_mem[frm_raddr];
	end

	// Component map, two read ports for the closure pass. Every vertex that
	// the last compute reached has its entry written by the time the block
	// is idle again, so the visit flags also mark the valid map entries.
	always_ff @(posedge clk) begin
		if (state_q == S_POPW) begin
			comp_mem[vstk_rd_q[VW-1:0]] <= comp_id_q;
		end
		comp_rd_a_q <= comp_mem[comp_raddr_a];
		comp_rd_b_q <= comp_mem[comp_raddr_b];
		cv_a_q      <= vis_valid_q[comp_raddr_a];
		cv_b_q      <= vis_valid_q[comp_raddr_b];
	end

	// Reach masks of the condensation.
	always_ff @(posedge clk) begin
		if (state_q == S_CWRITE) begin
			reach_mem[cls_c_q[CIW-1:0]] <= cls_s_q;
		end
		reach_rd_q <= reach_mem[reach_raddr];
		rv_q       <= rvalid_q[reach_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= VCNT_RESET;
			root_q      <= '0;
			vis_valid_q <= '0;
			onstk_q     <= '0;
			rvalid_q    <= '0;
			visit_ctr_q <= VISIT_W'(1);
			next_comp_q <= NC_W'(1);
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			depth_q     <= '0;
			sp_q        <= '0;
			done_q      <= 1'b0;
			out_id_q    <= '0;
			out_reach_q <= '0;
			cur_v_q     <= '0;
			cur_cur_q   <= '0;
			cur_low_q   <= '0;
			cur_num_q   <= '0;
			fsel_q      <= 1'b0;
			fpar_q      <= 1'b0;
			comp_id_q   <= '0;
			cls_c_q     <= '0;
			cls_e_q     <= '0;
			cls_s_q     <= '0;
			cls_ok_q    <= 1'b0;
			q_ok_q      <= 1'b0;
			r_ok_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				vcount_q <= cfg_data;
			end

			// Opening a vertex pushes it on both stacks and makes it the
			// current frame.
			if (do_open) begin
				vis_valid_q[open_v[VW-1:0]] <= 1'b1;
				onstk_q[open_v[VW-1:0]]     <= 1'b1;
				sp_q        <= sp_q + VCW'(1);
				depth_q     <= depth_q + VCW'(1);
				visit_ctr_q <= visit_ctr_q + VISIT_W'(1);
				cur_v_q     <= open_v;
				cur_cur_q   <= '0;
				cur_low_q   <= visit_ctr_q;
				cur_num_q   <= visit_ctr_q;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_id_q    <= '0;
						out_reach_q <= '0;
						unique case (op)
							OP_CLEAR: begin
								root_q      <= '0;
								vis_valid_q <= '0;
								onstk_q     <= '0;
								rvalid_q    <= '0;
								visit_ctr_q <= VISIT_W'(1);
								next_comp_q <= NC_W'(1);
								ovf_q       <= 1'b0;
								sp_q        <= '0;
								depth_q     <= '0;
								done_q      <= 1'b1;
							end
							OP_NEW_GRAPH: begin
								root_q <= '0;
								done_q <= 1'b1;
							end
							OP_MARK_ROOT: begin
								if (in_rng(first_vertex)) begin
									root_q[first_vertex[VW-1:0]] <= 1'b1;
								end
								done_q <= 1'b1;
							end
							OP_DIR_EDGE: begin
								if (dir_full) begin
									ovf_q <= 1'b1;
								end
								done_q <= 1'b1;
							end
							OP_UND_EDGE: begin
								if (und_full) begin
									ovf_q <= 1'b1;
								end
								done_q <= 1'b1;
							end
							OP_COMPUTE: begin
								vis_valid_q <= '0;
								onstk_q     <= '0;
								rvalid_q    <= '0;
								visit_ctr_q <= VISIT_W'(1);
								next_comp_q <= NC_W'(1);
								sp_q        <= '0;
								depth_q     <= '0;
								scan_q      <= '0;
								state_q     <= S_SCAN;
							end
							OP_READ_VERTEX: begin
								q_ok_q  <= (int'(first_vertex) < VSLOTS);
								state_q <= S_Q1;
							end
							OP_READ_COMP: begin
								out_id_q <= component_index;
								r_ok_q   <= (int'(component_index) < COMPONENT_LIMIT);
								state_q  <= S_Q2;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_Q1: begin
					out_id_q <= qid;
					r_ok_q   <= 1'b1;
					state_q  <= S_Q2;
				end
				S_Q2: begin
					out_reach_q <= (r_ok_q && rv_q) ? reach_rd_q : '0;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_end) begin
						cls_c_q <= NC_W'(1);
						cls_e_q <= '0;
						cls_s_q <= REACH_W'(2);
						if (next_comp_q <= NC_W'(1)) begin
							out_id_q    <= '0;
							out_reach_q <= '0;
							done_q      <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_CFETCH;
						end
					end else if (root_hit) begin
						state_q <= S_FETCH;
					end else begin
						scan_q <= scan_q + VCW'(1);
					end
				end
				S_FETCH: begin
					if (fetch_end) begin
						state_q <= S_FIN;
					end else begin
						fsel_q    <= !is_dir;
						fpar_q    <= udiff[0];
						cur_cur_q <= cur_cur_q + XW'(1);
						state_q   <= S_EDGE;
					end
				end
				S_EDGE: begin
					if (cand && vis_valid_q[cand_w[VW-1:0]] && onstk_q[cand_w[VW-1:0]]) begin
						state_q <= S_LOW;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_LOW: begin
					if (vis_rd_q < cur_low_q) begin
						cur_low_q <= vis_rd_q;
					end
					state_q <= S_FETCH;
				end
				S_FIN: begin
					if (cur_low_q == cur_num_q) begin
						if (int'(next_comp_q) < COMPONENT_LIMIT) begin
							comp_id_q   <= ID_W'(next_comp_q);
							next_comp_q <= next_comp_q + NC_W'(1);
						end else begin
							comp_id_q <= '0;
							ovf_q     <= 1'b1;
						end
						state_q <= S_POPR;
					end else begin
						state_q <= S_RET;
					end
				end
				S_POPR: begin
					sp_q    <= sp_q - VCW'(1);
					state_q <= S_POPW;
				end
				S_POPW: begin
					onstk_q[vstk_rd_q[VW-1:0]] <= 1'b0;
					state_q <= (vstk_rd_q == cur_v_q) ? S_RET : S_POPR;
				end
				S_RET: begin
					depth_q <= depth_q - VCW'(1);
					state_q <= (depth_q == VCW'(1)) ? S_SCAN : S_REST;
				end
				S_REST: begin
					cur_v_q   <= frm_rd_q[FW-1 -: VTX_W];
					cur_cur_q <= frm_rd_q[2*VISIT_W +: XW];
					cur_num_q <= frm_rd_q[0 +: VISIT_W];
					if (cur_low_q < frm_rd_q[VISIT_W +: VISIT_W]) begin
						cur_low_q <= cur_low_q;
					end else begin
						cur_low_q <= frm_rd_q[VISIT_W +: VISIT_W];
					end
					state_q <= S_FETCH;
				end
				S_CFETCH: begin
					if (cls_e_q >= dir_total) begin
						state_q <= S_CWRITE;
					end else begin
						cls_e_q <= cls_e_q + DTW'(1);
						state_q <= S_CCOMP;
					end
				end
				S_CCOMP: begin
					cls_ok_q <= in_rng(dir_rdata[EDGE_W-1 -: VTX_W])
						&& in_rng(dir_rdata[VTX_W-1:0]);
					state_q  <= S_CREACH;
				end
				S_CREACH: begin
					state_q <= (cls_ok_q && ca == ID_W'(cls_c_q)) ? S_COR : S_CFETCH;
				end
				S_COR: begin
					if (rv_q) begin
						cls_s_q <= cls_s_q | reach_rd_q;
					end
					state_q <= S_CFETCH;
				end
				S_CWRITE: begin
					rvalid_q[cls_c_q[CIW-1:0]] <= 1'b1;
					cls_c_q <= cls_c_q + NC_W'(1);
					cls_e_q <= '0;
					cls_s_q <= REACH_W'(1) << (cls_c_q + NC_W'(1));
					if ((cls_c_q + NC_W'(1)) >= next_comp_q) begin
						out_id_q    <= '0;
						out_reach_q <= '0;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_CFETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign component_id    = out_id_q;
	assign reach_set       = out_reach_q;
	assign component_count = ID_W'(next_comp_q - NC_W'(1));
	assign overflow        = ovf_q;

	// An idle block has no open search frames and an empty vertex stack.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (depth_q == '0 && sp_q == '0))
		else $error("search state left behind after compute");

	// Loads answer in the very next cycle.
	a_load_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_MARK_ROOT || op == OP_DIR_EDGE || op == OP_UND_EDGE
		|| op == OP_NEW_GRAPH || op == OP_CLEAR)) |=> done_q)
		else $error("load command did not answer in one cycle");

	// A result transaction is only presented once the sequencer is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while busy");

	// The component numbering never passes the limit and never returns to zero.
	a_comp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(next_comp_q) <= COMPONENT_LIMIT) && (next_comp_q != '0))
		else $error("component number out of bounds");

endmodule

`default_nettype wire

/* hw/rtl/scc_edge_store.sv */
`default_nettype none

module scc_edge_store #(
	parameter int MAX_DIRECTED_EDGES   = scc_pkg::DEF_MAX_DIRECTED_EDGES,
	parameter int MAX_UNDIRECTED_EDGES = scc_pkg::DEF_MAX_UNDIRECTED_EDGES,
	localparam int DAW = (MAX_DIRECTED_EDGES > 1) ? $clog2(MAX_DIRECTED_EDGES) : 1,
	localparam int UAW = (MAX_UNDIRECTED_EDGES > 1) ? $clog2(MAX_UNDIRECTED_EDGES) : 1,
	localparam int DTW = $clog2(MAX_DIRECTED_EDGES + 1),
	localparam int UTW = $clog2(MAX_UNDIRECTED_EDGES + 1)
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  scc_pkg::edge_ctl_t               ctl,
	input  wire [scc_pkg::EDGE_W-1:0]        wr_data,
	input  wire [DAW-1:0]                    dir_raddr,
	input  wire [UAW-1:0]                    und_raddr,
	output logic [DTW-1:0]                   dir_total,
	output logic [UTW-1:0]                   und_total,
	output logic [scc_pkg::EDGE_W-1:0]       dir_rdata,
	output logic [scc_pkg::EDGE_W-1:0]       und_rdata
);
	import scc_pkg::*;

	logic [EDGE_W-1:0] dir_mem [MAX_DIRECTED_EDGES];
	logic [EDGE_W-1:0] und_mem [MAX_UNDIRECTED_EDGES];
	logic [DTW-1:0]    dir_total_q;
	logic [UTW-1:0]    und_total_q;
	logic              dir_we;
	logic              und_we;

	// A write into a full store is dropped; the sequencer flags overflow.
	assign dir_we = ctl.wr_dir && (dir_total_q < DTW'(MAX_DIRECTED_EDGES));
	assign und_we = ctl.wr_und && (und_total_q < UTW'(MAX_UNDIRECTED_EDGES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_total_q <= '0;
			und_total_q <= '0;
		end else begin
			if (ctl.clr_dir) begin
				dir_total_q <= '0;
			end else if (dir_we) begin
				dir_total_q <= dir_total_q + DTW'(1);
			end
			if (ctl.clr_und) begin
				und_total_q <= '0;
			end else if (und_we) begin
				und_total_q <= und_total_q + UTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_total_q[DAW-1:0]] <= wr_data;
		end
		dir_rdata <= dir_mem[dir_raddr];
	end

	always_ff @(posedge clk) begin
		if (und_we) begin
			und_mem[und_total_q[UAW-1:0]] <= wr_data;
		end
		und_rdata <= und_mem[und_raddr];
	end

	assign dir_total = dir_total_q;
	assign und_total = und_total_q;

endmodule

`default_nettype wire
